// ===== hw/rtl/firlp_pkg.sv =====
`default_nettype none

package firlp_pkg;

    // coefficient rom, q0.16, symmetric, sums to 65535
    localparam int ROM_TAPS       = 21;
    localparam int ROM_BITS       = 16;
    localparam int COEFF_MAX_BITS = 24;
    localparam int OUT_FIELD_BITS = 12;

    localparam int DEF_TAPS        = 21;
    localparam int DEF_COEFF_BITS  = 16;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam logic [ROM_BITS-1:0] COEF_ROM [ROM_TAPS] = '{
        16'd174,  16'd295,  16'd602,  16'd1151, 16'd1954, 16'd2966, 16'd4091,
        16'd5193, 16'd6121, 16'd6741, 16'd6959, 16'd6741, 16'd6121, 16'd5193,
        16'd4091, 16'd2966, 16'd1954, 16'd1151, 16'd602,  16'd295,  16'd174
    };

    // controller to datapath commands
    typedef struct packed {
        logic shift_in;
        logic start;
        logic mac;
        logic acc_en;
        logic load_out;
    } firlp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last_tap;
    } firlp_stat_t;

    // coefficient of tap k rescaled to cbits fraction bits, zero past the rom
    function automatic logic [COEFF_MAX_BITS-1:0] tap_coef(input int k, input int cbits);
        logic [COEFF_MAX_BITS-1:0] c;
        c = '0;
        if (k < ROM_TAPS)
        begin
            c = COEFF_MAX_BITS'(COEF_ROM[k]);
            if (cbits >= ROM_BITS)
            begin
                c = c << (cbits - ROM_BITS);
            end
            else
            begin
                c = (c + (COEFF_MAX_BITS'(1) << (ROM_BITS - cbits - 1))) >> (ROM_BITS - cbits);
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/firlp_ctrl.sv =====
`default_nettype none

module firlp_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output firlp_pkg::firlp_cmd_t      cmd,
    input  wire firlp_pkg::firlp_stat_t stat
);
    import firlp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_ROUND
    } state_t;

    state_t state_reg, state_next;
    logic   acc_en_reg, acc_en_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.acc_en     = acc_en_reg;
        acc_en_next    = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.shift_in = 1'b1;
                    cmd.start    = 1'b1;
                    state_next   = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac     = 1'b1;
                acc_en_next = 1'b1;
                if (stat.last_tap)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_en_reg    <= acc_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/firlp_datapath.sv =====
`default_nettype none

module firlp_datapath
#(
    parameter int TAPS        = firlp_pkg::DEF_TAPS,
    parameter int COEFF_BITS  = firlp_pkg::DEF_COEFF_BITS,
    parameter int SAMPLE_BITS = firlp_pkg::DEF_SAMPLE_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire firlp_pkg::firlp_cmd_t  cmd,
    output firlp_pkg::firlp_stat_t      stat,
    input  wire logic [SAMPLE_BITS-1:0] sample_in,
    output logic [SAMPLE_BITS-1:0]      sample_out
);
    import firlp_pkg::*;

    localparam int CNT_BITS  = $clog2(TAPS);
    localparam int PROD_BITS = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_BITS  = PROD_BITS + $clog2(TAPS) + 1;

    // line[0] newest sample, line[TAPS-1] oldest; rotates once per tap
    logic [SAMPLE_BITS-1:0]    line_reg [TAPS];
    logic [CNT_BITS-1:0]       tap_cnt_reg;
    logic [PROD_BITS-1:0]      prod_reg;
    logic [ACC_BITS-1:0]       acc_reg;
    logic [SAMPLE_BITS-1:0]    out_reg;

    logic [COEFF_MAX_BITS-1:0] coef_full;
    logic [COEFF_BITS-1:0]     coef;
    logic [ACC_BITS:0]         rounded;
    logic [ACC_BITS-COEFF_BITS:0] scaled;
    logic [SAMPLE_BITS-1:0]    sat;
    logic [SAMPLE_BITS-1:0]    result;

    assign coef_full     = tap_coef(int'(tap_cnt_reg), COEFF_BITS);
    assign coef          = coef_full[COEFF_BITS-1:0];
    assign stat.last_tap = (tap_cnt_reg == '0);

    // round half up, drop fraction, clamp to full scale
    assign rounded = {1'b0, acc_reg} + ((ACC_BITS+1)'(1) << (COEFF_BITS - 1));
    assign scaled  = rounded[ACC_BITS:COEFF_BITS];
    assign sat     = (scaled > (ACC_BITS-COEFF_BITS+1)'({SAMPLE_BITS{1'b1}}))
                   ? {SAMPLE_BITS{1'b1}} : scaled[SAMPLE_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < SAMPLE_BITS; i++)
        begin
            result[i] = (i < OUT_FIELD_BITS) ? sat[i] : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (cmd.shift_in)
        begin
            line_reg[0] <= sample_in;
            for (int i = 1; i < TAPS; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
        else if (cmd.mac)
        begin
            line_reg[0] <= line_reg[TAPS-1];
            for (int i = 1; i < TAPS; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_cnt_reg <= '0;
        end
        else if (cmd.start)
        begin
            tap_cnt_reg <= CNT_BITS'(TAPS - 1);
        end
        else if (cmd.mac && !stat.last_tap)
        begin
            tap_cnt_reg <= tap_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac)
        begin
            prod_reg <= PROD_BITS'(line_reg[TAPS-1]) * PROD_BITS'(coef);
        end
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        end
        if (cmd.load_out)
        begin
            out_reg <= result;
        end
    end

    assign sample_out = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fir_lowpass_21_tap.sv =====
`default_nettype none
// a beat is taken only in idle; no new beat is taken until its result has been
//   rounded and handed to the output register, using the single shared
//   multiply-accumulate that walks the taps one per cycle
// a finished result waits in the output register while the next beat is taken
// reset: asynchronous active low, clears the delay line and all control state

module fir_lowpass_21_tap
#(
    parameter int TAPS        = firlp_pkg::DEF_TAPS,
    parameter int COEFF_BITS  = firlp_pkg::DEF_COEFF_BITS,
    parameter int SAMPLE_BITS = firlp_pkg::DEF_SAMPLE_BITS
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample_in
    // output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_tdata   // sample_out
);
    import firlp_pkg::*;

    localparam int BUS_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    firlp_cmd_t             cmd;
    firlp_stat_t            stat;
    logic [SAMPLE_BITS-1:0] sample_out;

    // sequencer: idle, tap walk, accumulator flush, round and hand off
    firlp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // rotating delay line, coefficient table, multiplier and accumulator;
    // bits of the input beat above the sample width are ignored
    firlp_datapath
    #(
        .TAPS        (TAPS),
        .COEFF_BITS  (COEFF_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
        .sample_out (sample_out)
    );

    // zero fill up to whole bytes
    assign m_tdata = BUS_BITS'(sample_out);

    // a taken beat starts the tap walk at the oldest tap
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!s_tready && !stat.last_tap))
        else $error("tap walk did not start after input beat");

    // a result appears only at the end of a walk, never straight from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("output beat raised outside the round step");

    // a new result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while pending");

endmodule

`default_nettype wire
